>>> src/lsa_pkg.sv
// Shared types, register indexes and constants for the lidar sector avoidance block.
package lsa_pkg;

    localparam int RANGE_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int HALF_W      = 15;
    localparam int CMP_W       = 18;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 72;
    localparam int HALF_TURN   = 18000;

    localparam logic [CFG_IDX_W-1:0] REG_SAFE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DANGER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_DANGER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_HALF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_HALF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_HALF   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEIL  = 3'd7;

    typedef enum logic [1:0] {
        MODE_FORWARD   = 2'd0,
        MODE_SLOW_TURN = 2'd1,
        MODE_RETREAT   = 2'd2,
        MODE_ROTATE    = 2'd3
    } motion_mode_t;

    typedef struct packed {
        logic [RANGE_W-1:0] safe_distance_mm;
        logic [RANGE_W-1:0] danger_distance_mm;
        logic [RANGE_W-1:0] rear_danger_distance_mm;
        logic [HALF_W-1:0]  front_half_cdeg;
        logic [HALF_W-1:0]  side_edge_cdeg;
        logic [HALF_W-1:0]  rear_half_cdeg;
        logic [RANGE_W-1:0] range_floor_mm;
        logic [RANGE_W-1:0] range_ceiling_mm;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] front_min_mm;
        logic [RANGE_W-1:0] left_min_mm;
        logic [RANGE_W-1:0] right_min_mm;
        logic [RANGE_W-1:0] rear_min_mm;
    } sector_min_t;

    typedef struct packed {
        motion_mode_t motion_mode;
        logic         turn_left;
    } decision_t;

endpackage

>>> src/lidar_sector_avoidance_top.sv
// Top level of the lidar sector avoidance block: input register, sector update and result register.
//
// Each accepted sample is held in the input register, then updates the four sector
// minima and, if it closes the scan, loads one result into the output register. A new sample
// can be accepted every cycle; the sample stage waits only when it holds a scan-closing sample
// while the previous result is still unclaimed, so a closing sample passes through the input
// register and then the output register before its result appears on m_tdata, and waits longer
// only while the previous result waits. Configuration writes are taken every cycle.
module lidar_sector_avoidance_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample_angle [15:0], sample_range_mm [31:16]
    input  logic [lsa_pkg::S_TDATA_W-1:0]   s_tdata,
    // sample_finite [0]
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // motion_mode [1:0], turn_left [2], front_min_mm [18:3], left_min_mm [34:19],
    // right_min_mm [50:35], rear_min_mm [66:51], zero [71:67]
    output logic [lsa_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lsa_pkg::*;

    cfg_t        cfg;
    sector_min_t mins_next;
    decision_t   decision;

    logic                      in_valid_reg;
    logic signed [ANGLE_W-1:0] in_angle_reg;
    logic [RANGE_W-1:0]        in_range_reg;
    logic                      in_finite_reg;
    logic                      in_last_reg;
    logic                      advance;
    logic                      sample_en;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [M_TDATA_W-1:0]      out_data_reg;

    lsa_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsa_sector_min u_min (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .sample_en       (sample_en),
        .sample_angle    (in_angle_reg),
        .sample_range_mm (in_range_reg),
        .sample_finite   (in_finite_reg),
        .last_in_scan    (in_last_reg),
        .cfg             (cfg),
        .mins_next       (mins_next)
    );

    lsa_decide u_decide (
        .mins     (mins_next),
        .cfg      (cfg),
        .decision (decision)
    );

    assign advance   = !in_last_reg || !out_valid_reg || m_tready;
    assign sample_en = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (sample_en && in_last_reg) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_angle_reg  <= signed'(s_tdata[ANGLE_W-1:0]);
            in_range_reg  <= s_tdata[ANGLE_W+RANGE_W-1:ANGLE_W];
            in_finite_reg <= s_tuser;
            in_last_reg   <= s_tlast;
        end
        if (sample_en && in_last_reg) begin
            out_data_reg <= {5'd0, mins_next.rear_min_mm, mins_next.right_min_mm,
                             mins_next.left_min_mm, mins_next.front_min_mm,
                             decision.turn_left, decision.motion_mode};
        end
    end

endmodule

>>> src/lsa_cfg_regs.sv
// Configuration register file written through the configuration request channel.
module lsa_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsa_pkg::CFG_DATA_W-1:0] cfg_data,
    output lsa_pkg::cfg_t                  cfg
);
    import lsa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SAFE:        cfg_next.safe_distance_mm        = cfg_data;
                REG_DANGER:      cfg_next.danger_distance_mm      = cfg_data;
                REG_REAR_DANGER: cfg_next.rear_danger_distance_mm = cfg_data;
                REG_FRONT_HALF:  cfg_next.front_half_cdeg         = cfg_data[HALF_W-1:0];
                REG_SIDE_HALF:   cfg_next.side_edge_cdeg          = cfg_data[HALF_W-1:0];
                REG_REAR_HALF:   cfg_next.rear_half_cdeg          = cfg_data[HALF_W-1:0];
                REG_RANGE_FLOOR: cfg_next.range_floor_mm          = cfg_data;
                REG_RANGE_CEIL:  cfg_next.range_ceiling_mm        = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.safe_distance_mm        <= 16'd500;
            cfg_reg.danger_distance_mm      <= 16'd250;
            cfg_reg.rear_danger_distance_mm <= 16'd300;
            cfg_reg.front_half_cdeg         <= 15'd3000;
            cfg_reg.side_edge_cdeg          <= 15'd6000;
            cfg_reg.rear_half_cdeg          <= 15'd3000;
            cfg_reg.range_floor_mm          <= 16'd0;
            cfg_reg.range_ceiling_mm        <= 16'hFFFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/lsa_sector_min.sv
// Per-scan running minima of the front, left, right and rear sectors.
module lsa_sector_min (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 sample_en,
    input  logic signed [lsa_pkg::ANGLE_W-1:0]   sample_angle,
    input  logic [lsa_pkg::RANGE_W-1:0]          sample_range_mm,
    input  logic                                 sample_finite,
    input  logic                                 last_in_scan,
    input  lsa_pkg::cfg_t                        cfg,
    output lsa_pkg::sector_min_t                 mins_next
);
    import lsa_pkg::*;

    sector_min_t mins_reg;
    logic        fresh_reg;
    sector_min_t base;

    logic signed [CMP_W-1:0] a_ext;
    logic signed [CMP_W-1:0] f_pos;
    logic signed [CMP_W-1:0] f_neg;
    logic signed [CMP_W-1:0] s_pos;
    logic signed [CMP_W-1:0] s_neg;
    logic signed [CMP_W-1:0] rear_hi;
    logic signed [CMP_W-1:0] rear_lo;
    logic                    counted;
    logic                    in_front;
    logic                    in_left;
    logic                    in_right;
    logic                    in_rear;

    always_comb begin
        a_ext   = CMP_W'(sample_angle);
        f_pos   = signed'({{(CMP_W-HALF_W){1'b0}}, cfg.front_half_cdeg});
        s_pos   = signed'({{(CMP_W-HALF_W){1'b0}}, cfg.side_edge_cdeg});
        f_neg   = -f_pos;
        s_neg   = -s_pos;
        rear_hi = CMP_W'(HALF_TURN)
                  - signed'({{(CMP_W-HALF_W){1'b0}}, cfg.rear_half_cdeg});
        rear_lo = signed'({{(CMP_W-HALF_W){1'b0}}, cfg.rear_half_cdeg})
                  - CMP_W'(HALF_TURN);

        counted  = sample_finite && (sample_range_mm >= cfg.range_floor_mm)
                   && (sample_range_mm <= cfg.range_ceiling_mm);
        in_front = (a_ext >= f_neg) && (a_ext <= f_pos);
        in_left  = (a_ext >= f_pos) && (a_ext <= s_pos);
        in_right = (a_ext >= s_neg) && (a_ext <= f_neg);
        in_rear  = (a_ext >= rear_hi) || (a_ext <= rear_lo);

        if (fresh_reg) begin
            base = '{cfg.range_ceiling_mm, cfg.range_ceiling_mm,
                     cfg.range_ceiling_mm, cfg.range_ceiling_mm};
        end else begin
            base = mins_reg;
        end

        mins_next = base;
        if (counted && in_front && (sample_range_mm < base.front_min_mm)) begin
            mins_next.front_min_mm = sample_range_mm;
        end
        if (counted && in_left && (sample_range_mm < base.left_min_mm)) begin
            mins_next.left_min_mm = sample_range_mm;
        end
        if (counted && in_right && (sample_range_mm < base.right_min_mm)) begin
            mins_next.right_min_mm = sample_range_mm;
        end
        if (counted && in_rear && (sample_range_mm < base.rear_min_mm)) begin
            mins_next.rear_min_mm = sample_range_mm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mins_reg  <= '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            fresh_reg <= 1'b1;
        end else if (sample_en) begin
            mins_reg  <= mins_next;
            fresh_reg <= last_in_scan;
        end
    end

endmodule

>>> src/lsa_decide.sv
// Motion mode and turn direction chosen from the sector minima at the end of a scan.
module lsa_decide (
    input  lsa_pkg::sector_min_t mins,
    input  lsa_pkg::cfg_t        cfg,
    output lsa_pkg::decision_t   decision
);
    import lsa_pkg::*;

    always_comb begin
        decision.turn_left = (mins.left_min_mm >= mins.right_min_mm);
        if (mins.front_min_mm > cfg.safe_distance_mm) begin
            decision.motion_mode = MODE_FORWARD;
            decision.turn_left   = 1'b0;
        end else if (mins.front_min_mm > cfg.danger_distance_mm) begin
            decision.motion_mode = MODE_SLOW_TURN;
        end else if (mins.rear_min_mm > cfg.rear_danger_distance_mm) begin
            decision.motion_mode = MODE_RETREAT;
        end else begin
            decision.motion_mode = MODE_ROTATE;
        end
    end

endmodule
